[hdl/bsa_pkg.sv]
// shared types and constants of the bitmap slot allocator
package bsa_pkg;

  localparam int unsigned FIELD_W = 13;
  localparam logic [FIELD_W-1:0] RESET_RESERVED = 13'd12;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } bsa_kind_e;

  typedef enum logic [1:0] {
    STAT_OK            = 2'd0,
    STAT_FULL          = 2'd1,
    STAT_NOT_ALLOCATED = 2'd2,
    STAT_RESERVED      = 2'd3
  } bsa_status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_RESP
  } bsa_state_e;

  typedef struct packed {
    bsa_kind_e          kind;
    logic [FIELD_W-1:0] slot;
  } bsa_req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] granted_slot;
    bsa_status_e        status;
  } bsa_rsp_t;

endpackage

[hdl/bsa_ram.sv]
// bitmap word memory with one write port and one registered read port
module bsa_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/bsa_find.sv]
// lowest free grantable bit of one bitmap word
module bsa_find #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned XW        = 13,
  parameter int unsigned SLOTS     = 8192
) (
  input  logic [WORD_BITS-1:0]         word_i,
  input  logic [XW-1:0]                base_i,
  input  logic [XW-1:0]                floor_i,
  output logic                         hit_o,
  output logic [$clog2(WORD_BITS)-1:0] bit_o
);

  localparam int unsigned BW = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] cand;

  always_comb begin
    logic [XW-1:0] pos;
    pos = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      pos     = base_i + XW'(j);
      cand[j] = !word_i[j] && (pos >= floor_i) && (pos < XW'(SLOTS));
    end
  end

  always_comb begin
    bit_o = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (cand[j]) begin
        bit_o = BW'(j);
      end
    end
  end

  assign hit_o = |cand;

endmodule

[hdl/bitmap_slot_allocator_core.sv]
// bitmap slot allocator: sequencer walking the bitmap memory one word per cycle
// one item at a time: a request is taken only in the idle state, and each walk starts at word 0
// reset: a clearing pass writes zero to all WORD_COUNT words, one per cycle,
//   before the first item is taken; reserved_q resets to 12
module bitmap_slot_allocator_core #(
  parameter int unsigned SLOTS     = 8192,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bsa_pkg::bsa_req_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bsa_pkg::bsa_rsp_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [12:0]       cfg_data_i
);

  import bsa_pkg::*;

  localparam int unsigned WC = (SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW = (WC > 1) ? $clog2(WC) : 1;
  localparam int unsigned CW = $clog2(WC + 1);
  localparam int unsigned SW = $clog2(WC * WORD_BITS + 1);
  localparam int unsigned XW = (SW > FIELD_W) ? SW : FIELD_W;
  localparam int unsigned BW = $clog2(WORD_BITS);

  bsa_state_e state_q, state_d;

  logic [FIELD_W-1:0]   reserved_q;
  logic [CW-1:0]        clr_q, clr_d;
  logic [CW-1:0]        addr_q, addr_d;
  logic [XW-1:0]        base_q, base_d;
  logic                 pend_q, pend_d;
  logic [AW-1:0]        paddr_q, paddr_d;
  logic [XW-1:0]        pbase_q, pbase_d;
  bsa_kind_e            kind_q, kind_d;
  logic [FIELD_W-1:0]   slot_q, slot_d;
  logic [WORD_BITS-1:0] wdata_q, wdata_d;
  logic [FIELD_W-1:0]   res_slot_q, res_slot_d;
  bsa_status_e          res_stat_q, res_stat_d;
  logic                 out_valid_q, out_valid_d;
  bsa_rsp_t             out_q, out_d;

  logic [WORD_BITS-1:0] ram_rdata;
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;

  logic                 find_hit;
  logic [BW-1:0]        find_bit;

  logic          in_accept, in_bad, out_free, load;
  logic [XW-1:0] res_x, in_slot_x, off;
  logic [BW-1:0] off_bit;
  logic          alloc_hit, free_hit, free_set, scan_end, issue;

  bsa_ram #(
    .DEPTH (WC),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  bsa_find #(
    .WORD_BITS (WORD_BITS),
    .XW        (XW),
    .SLOTS     (SLOTS)
  ) u_find (
    .word_i  (ram_rdata),
    .base_i  (pbase_q),
    .floor_i (res_x),
    .hit_o   (find_hit),
    .bit_o   (find_bit)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign res_x     = XW'(reserved_q);
  assign in_slot_x = XW'(in_data_i.slot);
  assign in_bad    = (in_slot_x < res_x) || (in_slot_x >= XW'(SLOTS));

  // offset of the freed slot inside the word under evaluation
  assign off       = XW'(slot_q) - pbase_q;
  assign off_bit   = off[BW-1:0];
  assign alloc_hit = pend_q && (kind_q == KIND_ALLOC) && find_hit;
  assign free_hit  = pend_q && (kind_q == KIND_FREE) && (off < XW'(WORD_BITS));
  assign free_set  = ram_rdata[off_bit];
  assign scan_end  = !pend_q && (addr_q == CW'(WC));
  assign issue     = (state_q == S_SCAN) && !alloc_hit && !free_hit
                     && (addr_q != CW'(WC));

  assign out_free = !out_valid_q || !out_stall_i;
  assign load     = (state_q == S_RESP) && out_free;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == CW'(WC - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_accept) begin
          if (in_data_i.kind == KIND_FREE && in_bad) state_d = S_RESP;
          else                                        state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (alloc_hit)     state_d = S_WRITE;
        else if (free_hit) state_d = free_set ? S_WRITE : S_RESP;
        else if (scan_end) state_d = S_RESP;
      end
      S_WRITE: state_d = S_RESP;
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    clr_d       = clr_q;
    addr_d      = addr_q;
    base_d      = base_q;
    pend_d      = issue;
    paddr_d     = paddr_q;
    pbase_d     = pbase_q;
    kind_d      = kind_q;
    slot_d      = slot_q;
    wdata_d     = wdata_q;
    res_slot_d  = res_slot_q;
    res_stat_d  = res_stat_q;
    ram_we      = 1'b0;
    ram_waddr   = paddr_q;
    ram_wdata   = wdata_q;
    ram_re      = issue;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q[AW-1:0];
        ram_wdata = '0;
        clr_d     = clr_q + CW'(1);
      end
      S_IDLE: begin
        if (in_accept) begin
          kind_d     = in_data_i.kind;
          slot_d     = in_data_i.slot;
          addr_d     = '0;
          base_d     = '0;
          res_slot_d = '0;
          res_stat_d = (in_data_i.kind == KIND_FREE && in_bad) ? STAT_RESERVED
                                                                : STAT_FULL;
        end
      end
      S_SCAN: begin
        if (issue) begin
          paddr_d = addr_q[AW-1:0];
          pbase_d = base_q;
          addr_d  = addr_q + CW'(1);
          base_d  = base_q + XW'(WORD_BITS);
        end
        if (alloc_hit) begin
          wdata_d           = ram_rdata;
          wdata_d[find_bit] = 1'b1;
          res_slot_d        = FIELD_W'(pbase_q + XW'(find_bit));
          res_stat_d        = STAT_OK;
        end else if (free_hit) begin
          wdata_d          = ram_rdata;
          wdata_d[off_bit] = 1'b0;
          res_stat_d       = free_set ? STAT_OK : STAT_NOT_ALLOCATED;
        end
      end
      S_WRITE: begin
        ram_we = 1'b1;
      end
      S_RESP: begin
        if (load) begin
          out_valid_d        = 1'b1;
          out_d.granted_slot = res_slot_q;
          out_d.status       = res_stat_q;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      reserved_q  <= RESET_RESERVED;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        reserved_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    base_q     <= base_d;
    paddr_q    <= paddr_d;
    pbase_q    <= pbase_d;
    kind_q     <= kind_d;
    slot_q     <= slot_d;
    wdata_q    <= wdata_d;
    res_slot_q <= res_slot_d;
    res_stat_q <= res_stat_d;
    out_q      <= out_d;
  end

endmodule

[tb/sv/bsa_checker.sv]
// checker for the slot allocator: predicts each result from observed transfers and compares
module bsa_checker #(
  parameter int unsigned SLOTS     = 8192,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  bsa_pkg::bsa_req_t           in_data_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  bsa_pkg::bsa_rsp_t           out_data_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [bsa_pkg::FIELD_W-1:0] cfg_data_i,
  output int unsigned                 pending_o,
  output int unsigned                 errors_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import bsa_pkg::*;

  localparam int unsigned WORD_COUNT = (SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned SHOW_LIMIT = 10;

  logic [WORD_BITS-1:0] used_words [WORD_COUNT];
  logic [FIELD_W-1:0]   reserved_count;
  bsa_rsp_t             outcome_q [$];
  int unsigned          mismatches = 0;

  // updates the shadow bitmap for one request and returns the outcome it must give
  function automatic bsa_rsp_t apply_slot_request(bsa_req_t req);
    bsa_rsp_t    rsp;
    int unsigned s;
    rsp.granted_slot = '0;
    rsp.status       = STAT_FULL;
    if (req.kind == KIND_ALLOC) begin
      for (s = reserved_count; s < SLOTS; s++) begin
        if (!used_words[s / WORD_BITS][s % WORD_BITS]) begin
          used_words[s / WORD_BITS][s % WORD_BITS] = 1'b1;
          rsp.granted_slot = s[FIELD_W-1:0];
          rsp.status       = STAT_OK;
          break;
        end
      end
    end else if (req.slot < reserved_count || req.slot >= SLOTS) begin
      rsp.status = STAT_RESERVED;
    end else if (!used_words[req.slot / WORD_BITS][req.slot % WORD_BITS]) begin
      rsp.status = STAT_NOT_ALLOCATED;
    end else begin
      used_words[req.slot / WORD_BITS][req.slot % WORD_BITS] = 1'b0;
      rsp.status = STAT_OK;
    end
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bsa_rsp_t exp_rsp;
    if (!rst_ni) begin
      foreach (used_words[w]) used_words[w] = '0;
      reserved_count = RESET_RESERVED;
      outcome_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) reserved_count = cfg_data_i;
      if (in_valid_i && !in_stall_i) outcome_q.push_back(apply_slot_request(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (outcome_q.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT)
            $display("%0t: unexpected result granted_slot %0d status %0d", $time,
                     out_data_i.granted_slot, out_data_i.status);
        end else begin
          exp_rsp = outcome_q.pop_front();
          if (exp_rsp.granted_slot !== out_data_i.granted_slot ||
              exp_rsp.status !== out_data_i.status) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
              $display("%0t: mismatch granted_slot exp %0d got %0d, status exp %0d got %0d",
                       $time, exp_rsp.granted_slot, out_data_i.granted_slot,
                       exp_rsp.status, out_data_i.status);
          end
        end
      end
      pending_o <= outcome_q.size();
    end
    errors_o <= mismatches;
  end

endmodule

[tb/sv/testbench.sv]
// testbench top: drives slot requests and reservation writes, gives the verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bsa_pkg::*;

  localparam int unsigned SLOTS      = 8192;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned WORD_COUNT = SLOTS / WORD_BITS;
  localparam int unsigned TIMEOUT_NS = 4_000_000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid;
  logic               in_stall;
  bsa_req_t           in_data;
  logic               out_valid;
  logic               out_stall;
  bsa_rsp_t           out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [FIELD_W-1:0] cfg_data;
  int unsigned        pending;
  int unsigned        errors;

  bit                 pace_on = 1'b1;
  logic [FIELD_W-1:0] live_slots [$];
  bsa_kind_e          kind_q [$];
  int unsigned        n_req = 0;
  int unsigned        n_cfg = 0;
  int unsigned        status_hits [4] = '{default: 0};

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  bitmap_slot_allocator_core #(
    .SLOTS    (SLOTS),
    .WORD_BITS(WORD_BITS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  bsa_checker #(
    .SLOTS    (SLOTS),
    .WORD_BITS(WORD_BITS)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_data_i (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_data_i (cfg_data),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  // keep a pool of granted slots so that most frees hit a slot in use
  always @(posedge clk_i) begin
    bsa_kind_e done_kind;
    if (in_valid && !in_stall) kind_q.push_back(in_data.kind);
    if (out_valid && !out_stall && kind_q.size() != 0) begin
      done_kind = kind_q.pop_front();
      status_hits[int'(out_data.status)]++;
      if (done_kind == KIND_ALLOC && out_data.status == STAT_OK)
        live_slots.push_back(out_data.granted_slot);
    end
  end

  // receiver: after each transfer hold stall for a random count of cycles
  initial begin : result_pacing
    int unsigned hold;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      while (!(out_valid && !out_stall)) @(posedge clk_i);
      hold = pace_on ? $urandom_range(0, 3) : 0;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic issue(input bsa_kind_e kind, input logic [FIELD_W-1:0] slot);
    int unsigned gap;
    gap = pace_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{kind: kind, slot: slot};
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    n_req++;
  endtask

  // stop sending, wait for every outstanding result, then let the block settle
  task automatic drain(input int unsigned tail);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic write_reserved(input logic [FIELD_W-1:0] count);
    cfg_valid <= 1'b1;
    cfg_data  <= count;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    n_cfg++;
  endtask

  task automatic random_phase(input int unsigned n, input logic [FIELD_W-1:0] count,
                              input int unsigned alloc_pct);
    int unsigned        i;
    int unsigned        pick;
    int unsigned        idx;
    int unsigned        free_cut;
    logic [FIELD_W-1:0] slot;
    drain(8);
    write_reserved(count);
    free_cut = alloc_pct + (100 - alloc_pct) * 3 / 4;
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < alloc_pct) begin
        issue(KIND_ALLOC, FIELD_W'($urandom));
      end else if (pick < free_cut && live_slots.size() != 0) begin
        idx  = $urandom_range(0, live_slots.size() - 1);
        slot = live_slots[idx];
        live_slots.delete(idx);
        issue(KIND_FREE, slot);
      end else begin
        // stray frees: anywhere, or right at the reservation boundary
        case ($urandom_range(0, 3))
          0:       slot = count - 1'b1;
          1:       slot = count;
          default: slot = FIELD_W'($urandom);
        endcase
        issue(KIND_FREE, slot);
      end
    end
  endtask

  initial begin : stimulus
    rst_ni    <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset reservation of twelve
    issue(KIND_ALLOC, 13'h1fff);
    issue(KIND_ALLOC, 13'h0000);
    issue(KIND_FREE, 13'd13);
    issue(KIND_FREE, 13'd13);
    issue(KIND_FREE, 13'd0);
    issue(KIND_FREE, 13'd11);
    issue(KIND_FREE, 13'h1fff);
    issue(KIND_ALLOC, 13'h0aaa);

    // no reservation: slot zero is grantable
    drain(8);
    write_reserved(13'd0);
    issue(KIND_ALLOC, 13'h1555);
    issue(KIND_FREE, 13'd0);
    issue(KIND_ALLOC, 13'd0);
    issue(KIND_FREE, 13'h1555);
    issue(KIND_FREE, 13'h0aaa);

    // only the top slot left; slots granted below the new reservation stay in use
    drain(8);
    write_reserved(13'h1fff);
    issue(KIND_FREE, 13'd0);
    issue(KIND_FREE, 13'd12);
    issue(KIND_ALLOC, 13'd0);
    issue(KIND_ALLOC, 13'd0);
    issue(KIND_FREE, 13'h1ffe);
    issue(KIND_FREE, 13'h1fff);
    issue(KIND_ALLOC, 13'd0);

    random_phase(300, FIELD_W'($urandom_range(1, 40)), 45);
    random_phase(120, FIELD_W'(SLOTS - $urandom_range(8, 40)), 70);
    random_phase(130, FIELD_W'($urandom_range(0, SLOTS - 1)), 50);
    pace_on = 1'b0;
    random_phase(200, 13'd0, 50);
    pace_on = 1'b1;
    random_phase(200, FIELD_W'($urandom_range(100, 3000)), 45);

    drain(WORD_COUNT + 8);
    $display("%0d slot requests under %0d reservation settings", n_req, n_cfg + 1);
    $display("outcomes: %0d ok, %0d full, %0d not allocated, %0d reserved or out of range",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

endmodule
